// File: hdl/intensity_gamma_adjust_defines.svh
// Assertion macros for the intensity gamma adjust block
`ifndef INTENSITY_GAMMA_ADJUST_DEFINES_SVH
`define INTENSITY_GAMMA_ADJUST_DEFINES_SVH

// checked out of reset only
`define IGA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IGA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/igadj_pkg.sv
// Shared types, codes and constant functions for the intensity gamma adjust block
`default_nettype none
package igadj_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WBITS = 30;
	localparam int LEVEL_W = 8;
	localparam int GAMMA_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int LEVEL_MAX = 255;

	localparam logic [CFG_IDX_W-1:0] REG_IN_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd4;

	localparam logic [1:0] MODE_LOW = 2'd0;
	localparam logic [1:0] MODE_HIGH = 2'd1;
	localparam logic [1:0] MODE_CALC = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic       bad;
	} sb_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = v;
		res = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30
	function automatic logic [WBITS:0] exp2_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << (2 * WBITS + 1));
		for (int i = 1; i < k; i++) begin
			c = isqrt64(c << WBITS);
		end
		return c[WBITS:0];
	endfunction
endpackage
`default_nettype wire

// File: hdl/igadj_log.sv
// Pipelined -log2 of a Q0.F fraction by repeated squaring
`default_nettype none
module igadj_log #(
	parameter int FRAC_BITS = igadj_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          in_v,
	input  logic [FRAC_BITS-1:0]                          in_t,
	input  igadj_pkg::sb_t                                in_sb,
	output logic                                          out_v,
	output logic [FRAC_BITS+$clog2(FRAC_BITS+1)-1:0]      out_nl,
	output igadj_pkg::sb_t                                out_sb
);
	import igadj_pkg::*;

	localparam int XW = WBITS + 1;
	localparam int MW = $clog2(FRAC_BITS);
	localparam int NLW = FRAC_BITS + $clog2(FRAC_BITS + 1);

	logic [MW-1:0]        lead;
	logic [XW-1:0]        x0;
	logic [XW-1:0]        x_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] lf_s [0:FRAC_BITS];
	logic [MW-1:0]        m_s  [0:FRAC_BITS];
	logic                 v_s  [0:FRAC_BITS];
	sb_t                  sb_s [0:FRAC_BITS];
	logic [NLW-1:0]       nl;

	always_comb begin
		lead = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (in_t[i]) lead = MW'(i);
		end
	end

	assign x0 = XW'(in_t) << (WBITS - int'(lead));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x0;
			lf_s[0] <= '0;
			m_s[0] <= lead;
			sb_s[0] <= in_sb;
		end
	end

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
		logic [2*XW-1:0] sq;
		logic [XW:0]     sh;
		logic            hi;

		assign sq = x_s[k] * x_s[k];
		assign sh = sq[WBITS+XW:WBITS];
		assign hi = sh[XW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1] <= hi ? sh[XW:1] : sh[XW-1:0];
				lf_s[k+1] <= {lf_s[k][FRAC_BITS-2:0], hi};
				m_s[k+1] <= m_s[k];
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	assign nl = (NLW'(FRAC_BITS - int'(m_s[FRAC_BITS])) << FRAC_BITS) - NLW'(lf_s[FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= v_s[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_nl <= nl;
			out_sb <= sb_s[FRAC_BITS];
		end
	end
endmodule
`default_nettype wire

// File: hdl/igadj_exp.sv
// Pipelined gamma scaling and 2^-e evaluation
`default_nettype none
module igadj_exp #(
	parameter int FRAC_BITS = igadj_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic [igadj_pkg::GAMMA_W-1:0]                 gamma,
	input  logic                                          in_v,
	input  logic [FRAC_BITS+$clog2(FRAC_BITS+1)-1:0]      in_nl,
	input  igadj_pkg::sb_t                                in_sb,
	output logic                                          out_v,
	output logic [FRAC_BITS:0]                            out_r,
	output igadj_pkg::sb_t                                out_sb
);
	import igadj_pkg::*;

	localparam int XW = WBITS + 1;
	localparam int NLW = FRAC_BITS + $clog2(FRAC_BITS + 1);
	localparam int PW = NLW + GAMMA_W;
	localparam int EW = PW - 8;
	localparam int EIW = EW - FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [PW-1:0]        eprod;
	logic [EIW-1:0]       ei_s [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] ef_s [0:FRAC_BITS];
	logic [XW-1:0]        r_s  [1:FRAC_BITS];
	logic                 v_s  [0:FRAC_BITS];
	sb_t                  sb_s [0:FRAC_BITS];
	logic [FRAC_BITS:0]   q;
	logic [FRAC_BITS:0]   rc;
	logic [FRAC_BITS:0]   rsel;

	assign eprod = PW'(in_nl) * PW'(gamma);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ei_s[0] <= eprod[PW-1:8+FRAC_BITS];
			ef_s[0] <= eprod[8+FRAC_BITS-1:8];
			sb_s[0] <= in_sb;
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_mul
		localparam logic [XW-1:0] CK = exp2_const(k);
		logic [XW-1:0]        rin;
		logic [FRAC_BITS-1:0] g;
		logic [2*XW-1:0]      prod;

		if (k == 1) begin : g_first
			assign rin = XW'(1) << WBITS;
		end else begin : g_next
			assign rin = r_s[k-1];
		end

		assign g = -ef_s[k-1];
		assign prod = rin * CK;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= g[FRAC_BITS-k] ? prod[WBITS+XW-1:WBITS] : rin;
				ei_s[k] <= ei_s[k-1];
				ef_s[k] <= ef_s[k-1];
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	assign q = r_s[FRAC_BITS][WBITS:WBITS-FRAC_BITS];

	always_comb begin
		if (ei_s[FRAC_BITS] > EIW'(FRAC_BITS)) begin
			rc = '0;
		end else if (ef_s[FRAC_BITS] == '0) begin
			rc = ONE >> ei_s[FRAC_BITS];
		end else begin
			rc = q >> (ei_s[FRAC_BITS] + 1'b1);
		end
		case (sb_s[FRAC_BITS].mode)
			MODE_LOW:  rsel = '0;
			MODE_HIGH: rsel = ONE;
			MODE_CALC: rsel = rc;
			default:   rsel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= v_s[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_r <= rsel;
			out_sb <= sb_s[FRAC_BITS];
		end
	end
endmodule
`default_nettype wire

// File: hdl/intensity_gamma_adjust.sv
// Top level of the intensity gamma adjust pipeline
//
// Maps each 8-bit gray pixel through clamp, normalize, t^gamma and a linear
// output range. Input channel: in_valid / in_stall / pixel_in. Output channel:
// out_valid / out_stall / pixel_out / bad_config. A request moves when valid is
// high and stall is low at a rising edge of clk.
// Registers are written through cfg_valid / cfg_ready / cfg_index / cfg_data;
// cfg_ready is always high and writes to indexes above 4 are dropped.
// Write registers only while the pipeline is empty.
// Throughput: one pixel per clock while in_stall is low. The pipeline is made
// of the divider stages (four quotient bits each), one squaring per log stage
// and one constant multiply per exp2 stage.
// Reset (arst_n low) empties the pipeline and loads in_low 0, in_high 255,
// out_low 0, out_high 255, gamma 1.0.
// When the receiver stalls, the held result stays on the outputs and one more
// result lands in a skid register; in_stall rises as that register fills, and
// the whole pipeline holds until the skid register drains.
`default_nettype none
module intensity_gamma_adjust #(
	parameter int FRAC_BITS = igadj_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [igadj_pkg::LEVEL_W-1:0]   pixel_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [igadj_pkg::LEVEL_W-1:0]   pixel_out,
	output logic                            bad_config,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [igadj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [igadj_pkg::GAMMA_W-1:0]   cfg_data
);
	import igadj_pkg::*;

	localparam int DIV_STEPS = 4;
	localparam int DSTG = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NLW = FRAC_BITS + $clog2(FRAC_BITS + 1);
	localparam int PW = FRAC_BITS + LEVEL_W + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [LEVEL_W-1:0] in_low_q;
	logic [LEVEL_W-1:0] in_high_q;
	logic [LEVEL_W-1:0] out_low_q;
	logic [LEVEL_W-1:0] out_high_q;
	logic [GAMMA_W-1:0] gamma_q;

	logic               en;
	logic               accept;
	logic [LEVEL_W-1:0] span;
	logic [LEVEL_W-1:0] pix_c;
	logic [LEVEL_W-1:0] num_c;
	sb_t                sb_c;

	logic               v_s1;
	logic [LEVEL_W-1:0] n_s1;
	sb_t                sb_s1;

	logic [LEVEL_W-1:0]   drem_s [1:DSTG];
	logic [FRAC_BITS-1:0] dq_s   [1:DSTG];
	logic                 dv_s   [1:DSTG];
	sb_t                  dsb_s  [1:DSTG];

	logic                 log_v;
	logic [NLW-1:0]       log_nl;
	sb_t                  log_sb;
	logic                 exp_v;
	logic [FRAC_BITS:0]   exp_r;
	sb_t                  exp_sb;

	logic                 v_s2;
	logic [PW-1:0]        lo_prod_s2;
	logic [PW-1:0]        hi_prod_s2;
	logic                 bad_s2;
	logic [PW-1:0]        sum;
	logic [LEVEL_W:0]     lvl;
	logic [LEVEL_W-1:0]   core_pix;

	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   pix_q;
	logic                 bad_q;
	logic                 skid_v_q;
	logic [LEVEL_W-1:0]   skid_pix_q;
	logic                 skid_bad_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q <= 8'd0;
			in_high_q <= 8'd255;
			out_low_q <= 8'd0;
			out_high_q <= 8'd255;
			gamma_q <= 12'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IN_LOW:   in_low_q <= cfg_data[LEVEL_W-1:0];
				REG_IN_HIGH:  in_high_q <= cfg_data[LEVEL_W-1:0];
				REG_OUT_LOW:  out_low_q <= cfg_data[LEVEL_W-1:0];
				REG_OUT_HIGH: out_high_q <= cfg_data[LEVEL_W-1:0];
				REG_GAMMA:    gamma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;
	assign accept = in_valid && !in_stall;
	assign span = in_high_q - in_low_q;

	always_comb begin
		pix_c = pixel_in;
		if (pixel_in < in_low_q) pix_c = in_low_q;
		if (pixel_in > in_high_q) pix_c = in_high_q;
		num_c = pix_c - in_low_q;
		sb_c.bad = (in_low_q >= in_high_q);
		if (sb_c.bad) begin
			sb_c.mode = MODE_LOW;
		end else if (gamma_q == '0) begin
			sb_c.mode = MODE_HIGH;
		end else if (num_c == '0) begin
			sb_c.mode = MODE_LOW;
		end else if (num_c == span) begin
			sb_c.mode = MODE_HIGH;
		end else begin
			sb_c.mode = MODE_CALC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= num_c;
			sb_s1 <= sb_c;
		end
	end

	for (genvar s = 0; s < DSTG; s++) begin : g_div
		logic [LEVEL_W-1:0]   rin;
		logic [FRAC_BITS-1:0] qin;
		logic                 vin;
		sb_t                  sbin;
		logic [LEVEL_W-1:0]   rtmp;
		logic [FRAC_BITS-1:0] qtmp;
		logic [LEVEL_W:0]     r2;

		if (s == 0) begin : g_first
			assign rin = n_s1;
			assign qin = '0;
			assign vin = v_s1;
			assign sbin = sb_s1;
		end else begin : g_next
			assign rin = drem_s[s];
			assign qin = dq_s[s];
			assign vin = dv_s[s];
			assign sbin = dsb_s[s];
		end

		always_comb begin
			rtmp = rin;
			qtmp = qin;
			r2 = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (s * DIV_STEPS + j < FRAC_BITS) begin
					r2 = {rtmp, 1'b0};
					if (r2 >= {1'b0, span}) begin
						rtmp = LEVEL_W'(r2 - {1'b0, span});
						qtmp = {qtmp[FRAC_BITS-2:0], 1'b1};
					end else begin
						rtmp = r2[LEVEL_W-1:0];
						qtmp = {qtmp[FRAC_BITS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[s+1] <= 1'b0;
			end else if (en) begin
				dv_s[s+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[s+1] <= rtmp;
				dq_s[s+1] <= qtmp;
				dsb_s[s+1] <= sbin;
			end
		end
	end

	igadj_log #(
		.FRAC_BITS(FRAC_BITS)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (dv_s[DSTG]),
		.in_t   (dq_s[DSTG]),
		.in_sb  (dsb_s[DSTG]),
		.out_v  (log_v),
		.out_nl (log_nl),
		.out_sb (log_sb)
	);

	igadj_exp #(
		.FRAC_BITS(FRAC_BITS)
	) u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.gamma  (gamma_q),
		.in_v   (log_v),
		.in_nl  (log_nl),
		.in_sb  (log_sb),
		.out_v  (exp_v),
		.out_r  (exp_r),
		.out_sb (exp_sb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= exp_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_prod_s2 <= PW'(out_low_q) * PW'(ONE - exp_r);
			hi_prod_s2 <= PW'(out_high_q) * PW'(exp_r);
			bad_s2 <= exp_sb.bad;
		end
	end

	assign sum = lo_prod_s2 + hi_prod_s2;
	assign lvl = sum[PW-1:FRAC_BITS];
	assign core_pix = (lvl > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : lvl[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_v_q) begin
				out_valid_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_valid_q <= v_s2;
			end
		end else if (v_s2 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_v_q) begin
				pix_q <= skid_pix_q;
				bad_q <= skid_bad_q;
			end else begin
				pix_q <= core_pix;
				bad_q <= bad_s2;
			end
		end else if (v_s2 && en) begin
			skid_pix_q <= core_pix;
			skid_bad_q <= bad_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_q;
	assign bad_config = bad_q;
endmodule
`default_nettype wire

// File: hdl/igadj_checker.sv
// Port-level assertions for the intensity gamma adjust block, with bind
`default_nettype none
`include "intensity_gamma_adjust_defines.svh"
module igadj_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [igadj_pkg::LEVEL_W-1:0]   pixel_out,
	input logic                            bad_config
);
	`IGA_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(pixel_out) && $stable(bad_config)), "stalled result changed")
	`IGA_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "input stalled without output stall")
	`IGA_ASSERT(a_stall_release, (in_valid && !out_stall) |=> !in_stall, "input stalled after output drained")
	`IGA_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!out_valid && !in_stall), "not idle in reset")
endmodule

bind intensity_gamma_adjust igadj_checker u_igadj_checker (.*);
`default_nettype wire
